[hdl/i4dq_pkg.sv]
// ----------------------------------------------------------------------------
// i4dq_pkg: shared types and constants for the int4 group dequantizer
// field widths, payload structs and the quiet nan pattern
// ----------------------------------------------------------------------------
`default_nettype none

package i4dq_pkg;

    localparam int unsigned CodesPerWord = 8;
    localparam int unsigned CodeWidth    = 4;
    localparam int unsigned HalfWidth    = 16;
    localparam int unsigned SingleWidth  = 32;
    localparam logic [31:0] QnanBits     = 32'h7FC0_0000;

    typedef struct packed {
        logic [31:0] weight_word;
        logic [3:0]  zero_code;
        logic [15:0] scale_bits;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value_7;
        logic [31:0] value_6;
        logic [31:0] value_5;
        logic [31:0] value_4;
        logic [31:0] value_3;
        logic [31:0] value_2;
        logic [31:0] value_1;
        logic [31:0] value_0;
    } t_out_item;

    // decoded group scale shared by all eight lanes
    typedef struct packed {
        logic        nan_scale;
        logic        sgn;
        logic [10:0] sig;
        logic [5:0]  pow2_b;   // pow2 + 127 - 100, range 3..33
    } t_scale;

endpackage

`default_nettype wire

[hdl/i4dq_lane.sv]
// ----------------------------------------------------------------------------
// i4dq_lane: one code to single precision
// factor times scale significand, leading-one search and packing
// ----------------------------------------------------------------------------
`default_nettype none

module i4dq_lane (
    input  wire logic [3:0]     i_code,
    input  wire logic [3:0]     i_zero,
    input  wire i4dq_pkg::t_scale i_scale,
    output logic [31:0]         o_value
);

    logic signed [5:0] f;
    logic [4:0]        mag;
    logic [15:0]       prod;
    logic [3:0]        top;
    logic [7:0]        bexp;
    logic [22:0]       man;
    logic              neg;
    logic [38:0]       shifted;

    always_comb begin
        f   = $signed({2'b00, i_code}) - $signed({2'b00, i_zero}) - 6'sd1;
        neg = i_scale.sgn ^ f[5];
        mag = f[5] ? 5'(-f) : f[4:0];
        prod = {11'd0, mag} * {5'd0, i_scale.sig};
        top = '0;
        for (int k = 1; k < 16; k++) begin
            if (prod[k]) begin
                top = 4'(k);
            end
        end
        bexp    = 8'(8'(top) + 8'(i_scale.pow2_b) + 8'd100);
        shifted = {23'd0, prod} << (5'd23 - 5'(top));
        man     = shifted[22:0];
        if (i_scale.nan_scale) begin
            o_value = i4dq_pkg::QnanBits;
        end else if (f == 6'sd0 || i_scale.sig == '0) begin
            o_value = '0;
        end else begin
            o_value = {neg, bexp, man};
        end
    end

endmodule

`default_nettype wire

[hdl/int4_group_dequantizer.sv]
// ----------------------------------------------------------------------------
// int4_group_dequantizer: gptq-style int4 weight dequantization
// eight codes of one word times the group half scale, single-precision out
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      i_valid / o_stall       i_item  (t_in_item)
// out      output     o_valid / i_stall       o_item  (t_out_item)
//
// one item per cycle while the output is not stalled; data passes the input and result register
// the only limit is the lane logic between the two registers
// synchronous active-low reset clears the valid flags only
// output stall propagates to input stall only when the result register is full
// and the input register is occupied as well
// ----------------------------------------------------------------------------
`default_nettype none

module int4_group_dequantizer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire i4dq_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output i4dq_pkg::t_out_item      o_item
);

    logic                r_in_valid;
    i4dq_pkg::t_in_item  r_in;
    logic                r_out_valid;
    i4dq_pkg::t_out_item r_out;
    i4dq_pkg::t_out_item n_out;
    i4dq_pkg::t_scale    scale;
    logic [4:0]          hexp;
    logic [31:0]         vals [8];
    logic                out_free;
    logic                in_free;

    assign out_free = !r_out_valid || !i_stall;
    assign in_free  = !r_in_valid || out_free;
    assign o_stall  = !in_free;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_comb begin
        hexp            = r_in.scale_bits[14:10];
        scale.nan_scale = (hexp == 5'h1F);
        scale.sgn       = r_in.scale_bits[15];
        scale.sig       = {(hexp != 5'd0), r_in.scale_bits[9:0]};
        // normal: hexp - 25 + 127 - 100; subnormal: -24 + 27
        scale.pow2_b    = (hexp == 5'd0) ? 6'd3 : 6'({1'b0, hexp} + 6'd2);
    end

    for (genvar g = 0; g < 8; g++) begin : g_lane
        i4dq_lane u_lane (
            .i_code  (r_in.weight_word[4*g +: 4]),
            .i_zero  (r_in.zero_code),
            .i_scale (scale),
            .o_value (vals[g])
        );
    end

    assign n_out = {vals[7], vals[6], vals[5], vals[4],
                    vals[3], vals[2], vals[1], vals[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in <= i_item;
        end
        if (out_free && r_in_valid) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with free room");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_stall && !i_valid |=> r_out_valid)
        else $error("item lost between stages");
`endif

endmodule

`default_nettype wire

[dv/int4_dequant_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int4_dequant_checker: scoreboard for the int4 group dequantizer
// predicts the eight single-precision values of each accepted weight item and
// compares them in order with the results leaving the block
// ----------------------------------------------------------------------------
`default_nettype none

module int4_dequant_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_stall_in,
    input  wire i4dq_pkg::t_in_item  i_item,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire i4dq_pkg::t_out_item i_out_item,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results_seen
);

    i4dq_pkg::t_out_item expected_items[$];

    // one lane: (code - zero - 1) * half scale as single bits, always exact
    function automatic logic [31:0] dequant_lane(input logic [3:0] code,
            input logic [3:0] zero, input logic [15:0] scale);
        int          factor;
        logic        neg;
        logic [4:0]  hexp;
        logic [14:0] prod;
        logic [10:0] sig;
        int          pow2;
        int          msb;
        logic [31:0] frac;
        hexp = scale[14:10];
        if (hexp == 5'h1F) return i4dq_pkg::QnanBits;
        if (hexp == 0) begin
            sig = {1'b0, scale[9:0]};
            pow2 = -24;
        end else begin
            sig = {1'b1, scale[9:0]};
            pow2 = int'(hexp) - 25;
        end
        factor = int'(code) - int'(zero) - 1;
        if (factor == 0 || sig == 0) return 32'h0;
        neg = scale[15] ^ (factor < 0);
        prod = 15'(((factor < 0) ? -factor : factor) * int'(sig));
        msb = 0;
        for (int b = 0; b < 15; b++) if (prod[b]) msb = b;
        frac = 32'(prod) << (23 - msb);
        return {neg, 8'(msb + pow2 + 127), frac[22:0]};
    endfunction

    always @(posedge i_clk) begin
        i4dq_pkg::t_out_item exp_item;
        logic [31:0]         got;
        logic [31:0]         want;
        int                  errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_pending <= 0;
            expected_items.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_items.size() == 0) begin
                    $error("result with no expected item: %h", i_out_item);
                    errs++;
                end else begin
                    exp_item = expected_items.pop_front();
                    for (int i = 0; i < int'(i4dq_pkg::CodesPerWord); i++) begin
                        got  = i_out_item[32*i +: 32];
                        want = exp_item[32*i +: 32];
                        if (got !== want) begin
                            $error("value_%0d expected %h actual %h", i, want, got);
                            errs++;
                        end
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                for (int i = 0; i < int'(i4dq_pkg::CodesPerWord); i++)
                    exp_item[32*i +: 32] = dequant_lane(i_item.weight_word[4*i +: 4],
                                                        i_item.zero_code,
                                                        i_item.scale_bits);
                expected_items.push_back(exp_item);
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= expected_items.size();
        end
    end

endmodule

`default_nettype wire

[dv/tb_int4_group_dequantizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int4_group_dequantizer: stimulus and verdict for the int4 dequantizer
// directed scale and code corners, then random words under three idle mixes
// ----------------------------------------------------------------------------
`default_nettype none

module tb_int4_group_dequantizer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    i4dq_pkg::t_in_item  i_item = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    i4dq_pkg::t_out_item o_item;
    int                  fail_count, pending, results_seen;
    int                  send_idle_pct = 14, recv_idle_pct = 53;
    int                  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    int4_group_dequantizer uut (.*);

    int4_dequant_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_item(i_item), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_item(o_item), .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("int4_group_dequantizer test failed");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] word, input logic [3:0] zero,
                             input logic [15:0] scale);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= '{weight_word: word, zero_code: zero, scale_bits: scale};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] random_scale();
        case ($urandom_range(9))
            0: return {1'($urandom_range(1)), 5'h00, 10'($urandom)};
            1: return {1'($urandom_range(1)), 5'h1F, 10'($urandom)};
            2: return {1'($urandom_range(1)), 15'h0};
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] corner_scales[10] = '{16'h3C00, 16'hBC00, 16'h0000, 16'h8000,
            16'h0001, 16'h83FF, 16'h7BFF, 16'hFC00, 16'h7E01, 16'h0400};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corner_scales[k])
            send_word(32'hFEDC_BA98 ^ {32{k[0]}}, 4'(k), corner_scales[k]);
        send_word(32'h7654_3210, 4'h0, 16'h3C00);
        send_word(32'hFFFF_FFFF, 4'hF, 16'hC000);
        send_word(32'h0000_0000, 4'hF, 16'h7BFF);
        send_word(32'h0000_0000, 4'h0, 16'h0001);
        send_word(32'hFFFF_FFFF, 4'h0, 16'hFBFF);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 14 : 0;
            for (int n = 0; n < 300; n++)
                send_word($urandom, 4'($urandom), random_scale());
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("covered %0d results: scale corners incl subnormal, zero, inf, nan",
                 results_seen);
        $display("random words under sender-heavy, receiver-heavy and no idling");
        if (fail_count == 0) begin
            $display("int4_group_dequantizer test passed");
        end else begin
            $display("int4_group_dequantizer test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
hdl/i4dq_pkg.sv
hdl/i4dq_lane.sv
hdl/int4_group_dequantizer.sv
dv/int4_dequant_checker.sv
dv/tb_int4_group_dequantizer.sv
